// ===== rtl/sdt_pkg.sv =====
// Shared types and constants for the solar duty tracker.
// Holds handshake structs between controller and datapath, state and action codes.
// No dependencies.
package sdt_pkg;

    localparam int DUTY_BITS_DEF   = 16;
    localparam int SAMPLE_BITS_DEF = 12;
    localparam int COUNT_BITS      = 16;
    localparam int SUM_SHIFT       = 3;
    localparam int CFG_IDX_BITS    = 3;

    localparam int OUT_LIMIT_RST    = 1700;
    localparam int INPUT_FLOOR_RST  = 600;
    localparam int DUTY_FLOOR_RST   = 0;
    localparam int DUTY_CEILING_RST = 65535;
    localparam int DUTY_START_RST   = 0;

    localparam logic [COUNT_BITS-1:0] OVER_COUNT  = 16'd200;
    localparam logic [COUNT_BITS-1:0] UNDER_COUNT = 16'd100;
    localparam logic [COUNT_BITS-1:0] TRACK_COUNT = 16'd1000;

    localparam logic [CFG_IDX_BITS-1:0] CFG_OUT_LIMIT    = 3'd0;
    localparam logic [CFG_IDX_BITS-1:0] CFG_INPUT_FLOOR  = 3'd1;
    localparam logic [CFG_IDX_BITS-1:0] CFG_MANUAL_MODE  = 3'd2;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DUTY_FLOOR   = 3'd3;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DUTY_CEILING = 3'd4;
    localparam logic [CFG_IDX_BITS-1:0] CFG_DUTY_START   = 3'd5;

    typedef enum logic [2:0] {
        ACT_NONE   = 3'd0,
        ACT_OVER   = 3'd1,
        ACT_UNDER  = 3'd2,
        ACT_TRACK  = 3'd3,
        ACT_FILTER = 3'd4
    } t_action;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACCUM,
        ST_DIV_LOAD,
        ST_DIV,
        ST_DECIDE,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic capture;
        logic accum;
        logic div_load;
        logic div_step;
        logic decide;
        logic load_out;
    } t_dp_cmd;

    typedef struct packed {
        logic full_block;
        logic manual;
        logic out_free;
    } t_dp_stat;

endpackage

// ===== rtl/sdt_div.sv =====
// Restoring divider, one quotient bit per cycle while i_step is high.
// Uses sdt_pkg for default widths.
module sdt_div #(
    parameter int DIVIDEND_BITS = sdt_pkg::SAMPLE_BITS_DEF + sdt_pkg::COUNT_BITS,
    parameter int DIVISOR_BITS  = sdt_pkg::COUNT_BITS
) (
    input  logic                     i_clk,
    input  logic                     i_load,
    input  logic                     i_step,
    input  logic [DIVIDEND_BITS-1:0] i_dividend,
    input  logic [DIVISOR_BITS-1:0]  i_divisor,
    output logic [DIVIDEND_BITS-1:0] o_quotient
);

    logic [DIVISOR_BITS-1:0]  r_rem, n_rem;
    logic [DIVIDEND_BITS-1:0] r_quo, n_quo;
    logic [DIVISOR_BITS:0]    w_shift, w_diff, w_dvsr;

    always_comb begin
        w_dvsr  = {1'b0, i_divisor};
        w_shift = {r_rem, r_quo[DIVIDEND_BITS-1]};
        w_diff  = w_shift - w_dvsr;
        n_rem   = r_rem;
        n_quo   = r_quo;
        if (i_load) begin
            n_rem = '0;
            n_quo = i_dividend;
        end else if (i_step) begin
            if (w_shift >= w_dvsr) begin
                n_rem = w_diff[DIVISOR_BITS-1:0];
                n_quo = {r_quo[DIVIDEND_BITS-2:0], 1'b1};
            end else begin
                n_rem = w_shift[DIVISOR_BITS-1:0];
                n_quo = {r_quo[DIVIDEND_BITS-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_rem <= n_rem;
        r_quo <= n_quo;
    end

    assign o_quotient = r_quo;

endmodule

// ===== rtl/sdt_datapath.sv =====
// Datapath: config registers, filters, totals, averaging dividers, duty update, result register.
// Uses sdt_pkg and sdt_div; driven by sdt_ctrl through t_dp_cmd.
module sdt_datapath #(
    parameter int DUTY_BITS   = sdt_pkg::DUTY_BITS_DEF,
    parameter int SAMPLE_BITS = sdt_pkg::SAMPLE_BITS_DEF,
    parameter int IN_BITS     = ((3 * (SAMPLE_BITS + 2) + 7) / 8) * 8,
    parameter int OUT_BITS    = ((DUTY_BITS + 3 * SAMPLE_BITS + 7) / 8) * 8,
    parameter int CFG_BITS    = (DUTY_BITS > SAMPLE_BITS) ? DUTY_BITS : SAMPLE_BITS
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  sdt_pkg::t_dp_cmd                i_cmd,
    output sdt_pkg::t_dp_stat               o_stat,
    input  logic [IN_BITS-1:0]              i_s_axis_tdata,
    input  logic                            i_s_axis_tuser,
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [OUT_BITS-1:0]             o_m_axis_tdata,
    output logic [2:0]                      o_m_axis_tuser,
    input  logic                            i_cfg_we,
    input  logic [sdt_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [CFG_BITS-1:0]             i_cfg_wdata
);

    localparam int SUM_BITS   = SAMPLE_BITS + 2;
    localparam int TOTAL_BITS = SAMPLE_BITS + sdt_pkg::COUNT_BITS;
    localparam int CB         = sdt_pkg::COUNT_BITS;

    logic [SAMPLE_BITS-1:0] r_out_limit, r_input_floor;
    logic                   r_manual;
    logic [DUTY_BITS-1:0]   r_duty_floor, r_duty_ceiling;

    logic [SAMPLE_BITS-1:0] r_gate_lvl, r_in_lvl, r_out_lvl;
    logic [SAMPLE_BITS-1:0] n_gate_lvl, n_in_lvl, n_out_lvl;
    logic [TOTAL_BITS-1:0]  r_gate_tot, r_in_tot, r_out_tot;
    logic [TOTAL_BITS-1:0]  n_gate_tot, n_in_tot, n_out_tot;
    logic [CB-1:0]          r_count, n_count;
    logic [SAMPLE_BITS-1:0] r_last_avg, n_last_avg;
    logic                   r_dir_down, n_dir_down;
    logic [DUTY_BITS-1:0]   r_duty, n_duty;
    logic                   r_func;
    sdt_pkg::t_action       r_action, n_action;
    logic                   r_out_valid, n_out_valid;
    logic [DUTY_BITS-1:0]   r_res_duty;
    logic [SAMPLE_BITS-1:0] r_res_gate, r_res_in, r_res_out;
    sdt_pkg::t_action       r_res_action;

    logic [SUM_BITS-1:0]    w_gate_sum, w_in_sum, w_out_sum;
    logic [TOTAL_BITS:0]    w_gate_add, w_in_add, w_out_add;
    logic [TOTAL_BITS-1:0]  w_gate_q, w_in_q, w_out_q;
    logic [SAMPLE_BITS-1:0] w_in_avg, w_out_avg;
    logic                   w_over, w_under, w_track, w_flip, w_down;
    logic signed [DUTY_BITS+1:0] w_duty_ext, w_lo, w_hi, w_moved, w_clip;
    localparam logic signed [DUTY_BITS+1:0] ONE = {{(DUTY_BITS+1){1'b0}}, 1'b1};

    assign w_gate_sum = i_s_axis_tdata[SUM_BITS-1:0];
    assign w_in_sum   = i_s_axis_tdata[2*SUM_BITS-1:SUM_BITS];
    assign w_out_sum  = i_s_axis_tdata[3*SUM_BITS-1:2*SUM_BITS];

    sdt_div #(.DIVIDEND_BITS(TOTAL_BITS), .DIVISOR_BITS(CB)) u_div_in (
        .i_clk      (i_clk),
        .i_load     (i_cmd.div_load),
        .i_step     (i_cmd.div_step),
        .i_dividend (r_in_tot),
        .i_divisor  (r_count),
        .o_quotient (w_in_q)
    );

    sdt_div #(.DIVIDEND_BITS(TOTAL_BITS), .DIVISOR_BITS(CB)) u_div_out (
        .i_clk      (i_clk),
        .i_load     (i_cmd.div_load),
        .i_step     (i_cmd.div_step),
        .i_dividend (r_out_tot),
        .i_divisor  (r_count),
        .o_quotient (w_out_q)
    );

    assign w_in_avg  = w_in_q[SAMPLE_BITS-1:0];
    assign w_out_avg = w_out_q[SAMPLE_BITS-1:0];

    always_comb begin
        w_gate_add = {1'b0, r_gate_tot} + (TOTAL_BITS+1)'(r_gate_lvl);
        w_in_add   = {1'b0, r_in_tot} + (TOTAL_BITS+1)'(r_in_lvl);
        w_out_add  = {1'b0, r_out_tot} + (TOTAL_BITS+1)'(r_out_lvl);

        w_over  = (w_out_avg > r_out_limit) && (r_count > sdt_pkg::OVER_COUNT);
        w_under = (w_in_avg < r_input_floor) && (r_count > sdt_pkg::UNDER_COUNT);
        w_track = r_count > sdt_pkg::TRACK_COUNT;
        w_flip  = (w_out_avg < r_last_avg) || (r_duty == r_duty_floor)
                  || (r_duty == r_duty_ceiling);
        w_down  = (w_over || w_under) ? 1'b1 : (r_dir_down ^ w_flip);

        w_duty_ext = {2'b00, r_duty};
        w_lo       = {2'b00, r_duty_floor};
        w_hi       = {2'b00, r_duty_ceiling};
        w_moved    = w_down ? (w_duty_ext - ONE) : (w_duty_ext + ONE);
        w_clip     = (w_moved > w_hi) ? w_hi : w_moved;
        w_clip     = (w_clip < w_lo) ? w_lo : w_clip;

        n_gate_lvl  = r_gate_lvl;
        n_in_lvl    = r_in_lvl;
        n_out_lvl   = r_out_lvl;
        n_gate_tot  = r_gate_tot;
        n_in_tot    = r_in_tot;
        n_out_tot   = r_out_tot;
        n_count     = r_count;
        n_last_avg  = r_last_avg;
        n_dir_down  = r_dir_down;
        n_duty      = r_duty;
        n_action    = r_action;
        n_out_valid = r_out_valid && !i_m_axis_tready;

        if (i_cmd.capture) begin
            n_gate_lvl = (r_gate_lvl >> 1)
                         + SAMPLE_BITS'(w_gate_sum >> sdt_pkg::SUM_SHIFT);
            n_in_lvl   = (r_in_lvl >> 1)
                         + SAMPLE_BITS'(w_in_sum >> sdt_pkg::SUM_SHIFT);
            n_out_lvl  = (r_out_lvl >> 1)
                         + SAMPLE_BITS'(w_out_sum >> sdt_pkg::SUM_SHIFT);
        end

        if (i_cmd.accum) begin
            if (r_func) begin
                n_action   = sdt_pkg::ACT_NONE;
                n_gate_tot = w_gate_add[TOTAL_BITS] ? '1 : w_gate_add[TOTAL_BITS-1:0];
                n_in_tot   = w_in_add[TOTAL_BITS] ? '1 : w_in_add[TOTAL_BITS-1:0];
                n_out_tot  = w_out_add[TOTAL_BITS] ? '1 : w_out_add[TOTAL_BITS-1:0];
                if (r_count != '1) begin
                    n_count = r_count + CB'(1);
                end
            end else begin
                n_action = sdt_pkg::ACT_FILTER;
            end
        end

        if (i_cmd.decide && (w_over || w_under || w_track)) begin
            n_gate_tot = '0;
            n_in_tot   = '0;
            n_out_tot  = '0;
            n_count    = '0;
            n_duty     = w_clip[DUTY_BITS-1:0];
            if (w_over) begin
                n_action = sdt_pkg::ACT_OVER;
            end else if (w_under) begin
                n_action = sdt_pkg::ACT_UNDER;
            end else begin
                n_action   = sdt_pkg::ACT_TRACK;
                n_dir_down = w_down;
                n_last_avg = w_out_avg;
            end
        end

        if (i_cmd.load_out) begin
            n_out_valid = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_limit    <= SAMPLE_BITS'(sdt_pkg::OUT_LIMIT_RST);
            r_input_floor  <= SAMPLE_BITS'(sdt_pkg::INPUT_FLOOR_RST);
            r_manual       <= 1'b0;
            r_duty_floor   <= DUTY_BITS'(sdt_pkg::DUTY_FLOOR_RST);
            r_duty_ceiling <= DUTY_BITS'(sdt_pkg::DUTY_CEILING_RST);
            r_gate_lvl     <= '0;
            r_in_lvl       <= '0;
            r_out_lvl      <= '0;
            r_gate_tot     <= '0;
            r_in_tot       <= '0;
            r_out_tot      <= '0;
            r_count        <= '0;
            r_last_avg     <= '0;
            r_dir_down     <= 1'b0;
            r_duty         <= DUTY_BITS'(sdt_pkg::DUTY_START_RST);
            r_out_valid    <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    sdt_pkg::CFG_OUT_LIMIT:    r_out_limit    <= i_cfg_wdata[SAMPLE_BITS-1:0];
                    sdt_pkg::CFG_INPUT_FLOOR:  r_input_floor  <= i_cfg_wdata[SAMPLE_BITS-1:0];
                    sdt_pkg::CFG_MANUAL_MODE:  r_manual       <= i_cfg_wdata[0];
                    sdt_pkg::CFG_DUTY_FLOOR:   r_duty_floor   <= i_cfg_wdata[DUTY_BITS-1:0];
                    sdt_pkg::CFG_DUTY_CEILING: r_duty_ceiling <= i_cfg_wdata[DUTY_BITS-1:0];
                    // start duty is only seen through reset
                    sdt_pkg::CFG_DUTY_START: begin
                    end
                    default: begin
                    end
                endcase
            end
            r_gate_lvl  <= n_gate_lvl;
            r_in_lvl    <= n_in_lvl;
            r_out_lvl   <= n_out_lvl;
            r_gate_tot  <= n_gate_tot;
            r_in_tot    <= n_in_tot;
            r_out_tot   <= n_out_tot;
            r_count     <= n_count;
            r_last_avg  <= n_last_avg;
            r_dir_down  <= n_dir_down;
            r_duty      <= n_duty;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        if (i_cmd.capture) begin
            r_func <= i_s_axis_tuser;
        end
        if (i_cmd.load_out) begin
            r_res_duty   <= r_duty;
            r_res_gate   <= r_gate_lvl;
            r_res_in     <= r_in_lvl;
            r_res_out    <= r_out_lvl;
            r_res_action <= r_action;
        end
    end

    assign o_stat.full_block = r_func;
    assign o_stat.manual     = r_manual;
    assign o_stat.out_free   = !r_out_valid || i_m_axis_tready;

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = OUT_BITS'({r_res_out, r_res_in, r_res_gate, r_res_duty});
    assign o_m_axis_tuser  = r_res_action;

endmodule

// ===== rtl/sdt_ctrl.sv =====
// Controller: sequences capture, accumulate, divide, decide and result load.
// Uses sdt_pkg; commands sdt_datapath through t_dp_cmd and reads t_dp_stat.
module sdt_ctrl #(
    parameter int TOTAL_BITS = sdt_pkg::SAMPLE_BITS_DEF + sdt_pkg::COUNT_BITS
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  sdt_pkg::t_dp_stat i_stat,
    output sdt_pkg::t_dp_cmd  o_cmd
);

    localparam int STEP_BITS = $clog2(TOTAL_BITS);
    localparam logic [STEP_BITS-1:0] LAST_STEP = STEP_BITS'(TOTAL_BITS - 1);

    sdt_pkg::t_state      r_state, n_state;
    logic [STEP_BITS-1:0] r_step, n_step;

    always_comb begin
        n_state = r_state;
        n_step  = r_step;
        case (r_state)
            sdt_pkg::ST_IDLE: begin
                if (i_s_axis_tvalid) begin
                    n_state = sdt_pkg::ST_ACCUM;
                end
            end
            sdt_pkg::ST_ACCUM: begin
                if (i_stat.full_block && !i_stat.manual) begin
                    n_state = sdt_pkg::ST_DIV_LOAD;
                end else begin
                    n_state = sdt_pkg::ST_DONE;
                end
            end
            sdt_pkg::ST_DIV_LOAD: begin
                n_step  = '0;
                n_state = sdt_pkg::ST_DIV;
            end
            sdt_pkg::ST_DIV: begin
                n_step = r_step + STEP_BITS'(1);
                if (r_step == LAST_STEP) begin
                    n_state = sdt_pkg::ST_DECIDE;
                end
            end
            sdt_pkg::ST_DECIDE: begin
                n_state = sdt_pkg::ST_DONE;
            end
            sdt_pkg::ST_DONE: begin
                if (i_stat.out_free) begin
                    n_state = sdt_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = sdt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb begin
        o_s_axis_tready = (r_state == sdt_pkg::ST_IDLE);
        o_cmd           = '0;
        o_cmd.capture   = o_s_axis_tready && i_s_axis_tvalid;
        o_cmd.accum     = (r_state == sdt_pkg::ST_ACCUM);
        o_cmd.div_load  = (r_state == sdt_pkg::ST_DIV_LOAD);
        o_cmd.div_step  = (r_state == sdt_pkg::ST_DIV);
        o_cmd.decide    = (r_state == sdt_pkg::ST_DECIDE);
        o_cmd.load_out  = (r_state == sdt_pkg::ST_DONE) && i_stat.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sdt_pkg::ST_IDLE;
            r_step  <= '0;
        end else begin
            r_state <= n_state;
            r_step  <= n_step;
        end
    end

`ifndef SYNTHESIS
    a_capture_to_accum: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.capture |=> r_state == sdt_pkg::ST_ACCUM)
        else $error("request taken but accumulate step skipped");

    a_decide_after_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.decide |-> $past(r_state) == sdt_pkg::ST_DIV && $past(r_step) == LAST_STEP)
        else $error("decision made before division finished");

    a_manual_no_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.accum && i_stat.manual) |=> r_state == sdt_pkg::ST_DONE)
        else $error("division started in manual mode");

    a_single_command: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0({o_cmd.capture, o_cmd.accum, o_cmd.div_load, o_cmd.div_step,
                  o_cmd.decide, o_cmd.load_out}))
        else $error("overlapping datapath commands");
`endif

endmodule

// ===== rtl/solar_duty_tracker_core.sv =====
// Solar duty tracker top level: perturb-and-observe duty control on filtered channel sums.
// Uses sdt_pkg, sdt_ctrl, sdt_datapath (with two sdt_div dividers).
//
// One request is taken at a time. A half-block request, and a full-block request in manual
// mode, passes through the accumulate and done states before its result is loaded. A
// full-block request in automatic mode also passes through divider load, the divide steps
// and the decision; the two restoring dividers form the input and output averages side by
// side, one quotient bit per cycle over the full width of the totals. The result sits in an
// output register, so the next request is taken as soon as the current result is registered,
// even if it is not yet taken downstream. Configuration writes take effect on the next clock;
// duty_start only sets the duty at reset, where it is always its reset value of zero.
module solar_duty_tracker_core #(
    parameter int DUTY_BITS   = sdt_pkg::DUTY_BITS_DEF,
    parameter int SAMPLE_BITS = sdt_pkg::SAMPLE_BITS_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_s_axis_tvalid,
    output logic                             o_s_axis_tready,
    // gate_sum, input_sum, output_sum, zero fill
    input  logic [((3*(SAMPLE_BITS+2)+7)/8)*8-1:0] i_s_axis_tdata,
    // func
    input  logic                             i_s_axis_tuser,
    output logic                             o_m_axis_tvalid,
    input  logic                             i_m_axis_tready,
    // duty, gate_filtered, input_filtered, output_filtered, zero fill
    output logic [((DUTY_BITS+3*SAMPLE_BITS+7)/8)*8-1:0] o_m_axis_tdata,
    // action
    output logic [2:0]                       o_m_axis_tuser,
    input  logic                             i_cfg_we,
    input  logic [sdt_pkg::CFG_IDX_BITS-1:0] i_cfg_index,
    input  logic [((DUTY_BITS > SAMPLE_BITS) ? DUTY_BITS : SAMPLE_BITS)-1:0] i_cfg_wdata
);

    localparam int IN_BITS    = ((3 * (SAMPLE_BITS + 2) + 7) / 8) * 8;
    localparam int OUT_BITS   = ((DUTY_BITS + 3 * SAMPLE_BITS + 7) / 8) * 8;
    localparam int CFG_BITS   = (DUTY_BITS > SAMPLE_BITS) ? DUTY_BITS : SAMPLE_BITS;
    localparam int TOTAL_BITS = SAMPLE_BITS + sdt_pkg::COUNT_BITS;

    sdt_pkg::t_dp_cmd  w_cmd;
    sdt_pkg::t_dp_stat w_stat;

    sdt_ctrl #(.TOTAL_BITS(TOTAL_BITS)) u_ctrl (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_stat          (w_stat),
        .o_cmd           (w_cmd)
    );

    sdt_datapath #(
        .DUTY_BITS   (DUTY_BITS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .IN_BITS     (IN_BITS),
        .OUT_BITS    (OUT_BITS),
        .CFG_BITS    (CFG_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (w_cmd),
        .o_stat          (w_stat),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tuser  (i_s_axis_tuser),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_wdata     (i_cfg_wdata)
    );

endmodule
